[rtl/core/utf8_dec_pkg.sv]
// Package with the payload types, constants and helper functions of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8_dec_pkg;

  localparam logic [20:0] ReplacementCp = 21'h00FFFD;
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        last_of_run;
  } out_t;

  // Sequence length set by a lead byte: 1 to 4, or 0 for a byte that cannot lead.
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    priority if (c < 8'h80) begin
      len = 3'd1;
    end else if ((c & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((c & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((c & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Code point of a byte that stands alone, within a string or at its end.
  function automatic logic [20:0] single_cp(input logic [7:0] c);
    logic [20:0] cp;
    cp = (c < 8'h80) ? {13'd0, c} : ReplacementCp;
    return cp;
  endfunction

endpackage

[rtl/core/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: sequence tracking, decode logic and result register.
`timescale 1ns / 1ps

// The decoder takes one byte per cycle while its input is not stalled, and gives code
// points on its output channel. A byte that completes a sequence, or stands alone, yields
// its single result in the cycle after the transfer, and the next byte is taken in the same
// cycle as long as the result is taken too; bytes that are merely held yield nothing. When
// the string ends inside an unfinished sequence the final byte yields up to three results,
// which leave the result register one per cycle while the output is not stalled; the input
// stalls until the last is taken, as all results pass through the single-entry output port.
module utf8_stream_decoder
  import utf8_dec_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic [7:0]  held_q [3];
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [2:0]  seq_len_q, seq_len_d;
  logic [20:0] cp_q [3];
  logic [20:0] cp_d [3];
  logic [1:0]  rem_q, rem_d;
  logic [1:0]  idx_q, idx_d;
  logic [1:0]  new_cnt;
  logic        in_acc;
  logic        out_take;
  logic        hold_wr;

  assign out_valid_o = (rem_q != 2'd0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign in_stall_o  = out_valid_o && !(out_take && (rem_q == 2'd1));
  assign in_acc      = in_valid_i && !in_stall_o;

  assign out_o.code_point  = cp_q[idx_q];
  assign out_o.last_of_run = (rem_q == 2'd1);

  always_comb begin
    logic [7:0] b0, b1, b2, b3;
    logic [2:0] len_in;
    logic [2:0] len_r0;
    logic [2:0] n;
    logic       complete;

    b0 = held_q[0];
    b1 = (held_cnt_q >= 2'd2) ? held_q[1] : in_i.byte_in;
    b2 = (held_cnt_q == 2'd3) ? held_q[2] : in_i.byte_in;
    b3 = in_i.byte_in;
    len_in   = lead_len(in_i.byte_in);
    len_r0   = lead_len(b1);
    n        = {1'b0, held_cnt_q} + 3'd1;
    complete = (n >= seq_len_q);

    cp_d[0]    = ReplacementCp;
    cp_d[1]    = ReplacementCp;
    cp_d[2]    = ReplacementCp;
    new_cnt    = 2'd0;
    hold_wr    = 1'b0;
    held_cnt_d = held_cnt_q;
    seq_len_d  = seq_len_q;

    if (held_cnt_q == 2'd0) begin
      if ((len_in >= 3'd2) && !in_i.final_byte) begin
        hold_wr    = 1'b1;
        held_cnt_d = 2'd1;
        seq_len_d  = len_in;
      end else begin
        cp_d[0] = single_cp(in_i.byte_in);
        new_cnt = 2'd1;
      end
    end else if (complete || in_i.final_byte) begin
      held_cnt_d = 2'd0;
      seq_len_d  = 3'd0;
      if (complete) begin
        new_cnt = 2'd1;
        unique case (seq_len_q)
          3'd2:    cp_d[0] = {10'd0, b0[4:0], b1[5:0]};
          3'd3:    cp_d[0] = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
          default: cp_d[0] = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        endcase
      end else if (held_cnt_q == 2'd1) begin
        cp_d[1] = single_cp(b1);
        new_cnt = 2'd2;
      end else if (len_r0 == 3'd2) begin
        cp_d[1] = {10'd0, b1[4:0], b2[5:0]};
        new_cnt = 2'd2;
      end else begin
        cp_d[1] = single_cp(b1);
        cp_d[2] = single_cp(b2);
        new_cnt = 2'd3;
      end
    end else begin
      hold_wr    = 1'b1;
      held_cnt_d = held_cnt_q + 2'd1;
    end

    rem_d = rem_q;
    idx_d = idx_q;
    if (in_acc) begin
      rem_d = new_cnt;
      idx_d = 2'd0;
    end else if (out_take) begin
      rem_d = rem_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      seq_len_q  <= 3'd0;
      rem_q      <= 2'd0;
      idx_q      <= 2'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
      if (in_acc) begin
        held_cnt_q <= held_cnt_d;
        seq_len_q  <= seq_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && hold_wr) begin
      held_q[held_cnt_q] <= in_i.byte_in;
    end
    if (in_acc) begin
      cp_q[0] <= cp_d[0];
      cp_q[1] <= cp_d[1];
      cp_q[2] <= cp_d[2];
    end
  end

  a_held_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_cnt_q != 2'd0) |-> ({1'b0, held_cnt_q} < seq_len_q))
    else $error("held byte count has reached the sequence length");

  a_lead_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (held_cnt_q == 2'd0) && !in_i.final_byte && (lead_len(in_i.byte_in) >= 3'd2))
    |=> (held_cnt_q == 2'd1) && !out_valid_o)
    else $error("multi-byte lead was not held");

  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, idx_q} + {1'b0, rem_q} <= 3'(MaxResults)))
    else $error("result index runs past the result register");

  a_idle_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result pending");

endmodule

[tb/utf8_stream_decoder_test.sv]
// Testbench of the UTF-8 stream decoder: directed and random byte strings checked against a predictor.
`timescale 1ns / 1ps

module utf8_stream_decoder_test
  import utf8_dec_pkg::*;
();

  localparam int unsigned HoldCycles = 60;
  localparam int unsigned CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_o;

  out_t        expected_cps [$];
  logic [7:0]  str_bytes [$];
  logic [7:0]  pending_bytes [3];
  int unsigned pending_cnt = 0;
  int unsigned pending_len = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_pct = 13;
  int unsigned stall_pct = 13;
  logic        hold_req = 1'b0;

  utf8_stream_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned lead_span(input logic [7:0] b);
    int unsigned span;
    casez (b)
      8'b0???????: span = 1;
      8'b110?????: span = 2;
      8'b1110????: span = 3;
      8'b11110???: span = 4;
      default:     span = 0;
    endcase
    return span;
  endfunction

  // Decodes the bytes of a finished run or string end, each code point starting afresh, up to three.
  function automatic void flush_tail(input logic [31:0] run, input int unsigned n);
    int unsigned p;
    int unsigned k;
    int unsigned cnt;
    int unsigned j;
    logic [7:0]  lead;
    logic [7:0]  tail;
    out_t        res;
    p = 0;
    cnt = 0;
    while (p < n && cnt < 3) begin
      lead = run[8*p +: 8];
      k = lead_span(lead);
      if (k == 1) begin
        res.code_point = {13'd0, lead};
        p = p + 1;
      end else if (k >= 2 && p + k <= n) begin
        case (k)
          2:       res.code_point = {16'd0, lead[4:0]};
          3:       res.code_point = {17'd0, lead[3:0]};
          default: res.code_point = {18'd0, lead[2:0]};
        endcase
        for (j = 1; j < k; j++) begin
          tail = run[8*(p+j) +: 8];
          res.code_point = {res.code_point[14:0], tail[5:0]};
        end
        p = p + k;
      end else begin
        res.code_point = ReplacementCp;
        p = p + 1;
      end
      res.last_of_run = !(p < n && cnt < 2);
      expected_cps = {expected_cps, res};
      cnt++;
    end
  endfunction

  function automatic void predict_decode(input logic [7:0] b, input logic fin);
    logic [31:0] run;
    int unsigned len;
    int unsigned n;
    int unsigned i;
    if (pending_cnt == 0) begin
      len = lead_span(b);
      pending_len = 0;
      if (len >= 2 && !fin) begin
        pending_bytes[0] = b;
        pending_cnt = 1;
        pending_len = len;
      end else begin
        flush_tail({24'd0, b}, 1);
      end
    end else begin
      run = '0;
      for (i = 0; i < pending_cnt; i++) run[8*i +: 8] = pending_bytes[i];
      run[8*pending_cnt +: 8] = b;
      n = pending_cnt + 1;
      if (n >= pending_len || fin) begin
        flush_tail(run, n);
        pending_cnt = 0;
        pending_len = 0;
      end else begin
        pending_bytes[pending_cnt] = b;
        pending_cnt++;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [20:0] got,
                                 input logic [20:0] want);
    $display("mismatch at cycle %0d: %s, got %0h, expected %0h", cycle_cnt, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : monitor
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_cps.size() == 0) begin
          report_mismatch("code point with none expected", out_o.code_point, 21'd0);
        end else begin
          want = expected_cps.pop_front();
          if (out_o.code_point !== want.code_point)
            report_mismatch("code_point", out_o.code_point, want.code_point);
          if (out_o.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", {20'd0, out_o.last_of_run}, {20'd0, want.last_of_run});
        end
      end
      if (in_valid_i && !in_stall_o) predict_decode(in_i.byte_in, in_i.final_byte);
    end
  end

  initial begin : receiver
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= {b, fin};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_str();
    int unsigned i;
    for (i = 0; i < str_bytes.size(); i++) send_byte(str_bytes[i], i == str_bytes.size() - 1);
    str_bytes = {};
  endtask

  function automatic void add_char(input int unsigned len);
    logic [31:0] r;
    logic [7:0]  b;
    int unsigned i;
    r = $urandom;
    case (len)
      1:       b = {1'b0, r[6:0]};
      2:       b = {3'b110, r[4:0]};
      3:       b = {4'b1110, r[3:0]};
      default: b = {5'b11110, r[2:0]};
    endcase
    str_bytes = {str_bytes, b};
    for (i = 1; i < len; i++) begin
      r = $urandom;
      // Now and then a following byte is not of continuation form.
      b = (r[11:8] == 4'd0) ? r[7:0] : {2'b10, r[5:0]};
      str_bytes = {str_bytes, b};
    end
  endfunction

  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_complete_sequences();
    str_bytes = '{8'hC2, 8'hA9};
    send_str();
    str_bytes = '{8'hE2, 8'h82, 8'hAC};
    send_str();
    str_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_str();
    str_bytes = '{8'hC3, 8'h41};
    send_str();
  endtask

  task automatic test_truncated_ends();
    send_byte(8'hE2, 1'b1);
    str_bytes = '{8'hF0, 8'h9F, 8'h98};
    send_str();
    str_bytes = '{8'hF0, 8'hC3, 8'hA9};
    send_str();
    str_bytes = '{8'hE2, 8'hC3};
    send_str();
  endtask

  task automatic test_random_strings(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned c;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(99);
      len = 1;
      if (kind < 15) begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom_range(255));
          str_bytes = {str_bytes, b};
        end
      end else begin
        for (c = $urandom_range(1, 6); c > 0; c--) begin
          len = $urandom_range(1, 4);
          add_char(len);
        end
        // Some strings end inside their last sequence.
        if (kind >= 75 && len >= 2) begin
          repeat ($urandom_range(1, len - 1)) void'(str_bytes.pop_back());
        end
      end
      sent += str_bytes.size();
      send_str();
    end
  endtask

  task automatic test_output_hold_off();
    hold_req = 1'b1;
    str_bytes = '{8'hF0, 8'h41, 8'h42};
    send_str();
    test_random_strings(16);
  endtask

  task automatic test_back_to_back();
    gap_pct = 0;
    stall_pct = 0;
    test_random_strings(28);
    gap_pct = 13;
    stall_pct = 13;
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_bytes();
    test_complete_sequences();
    test_truncated_ends();
    test_random_strings(20);
    test_output_hold_off();
    test_back_to_back();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_cps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_cps.size() != 0)
      report_mismatch("results never delivered", 21'(expected_cps.size()), 21'd0);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
